FILE: sv/assert_macros.svh
// Assertion macros for the checker file mrfc_checker.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("assertion failed");

`endif

FILE: sv/mrfc_pkg.sv
// Types, constants and the CRC-16 byte update for the response frame checker.
// Depends on nothing.
package mrfc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam int unsigned LEN_BASE = 5;

    localparam int unsigned POS_ADDR  = 0;
    localparam int unsigned POS_FUNC  = 1;
    localparam int unsigned POS_COUNT = 2;
    localparam int unsigned POS_R0_HI = 3;
    localparam int unsigned POS_R0_LO = 4;
    localparam int unsigned POS_R1_HI = 5;
    localparam int unsigned POS_R1_LO = 6;

    typedef enum logic [1:0] {
        CFG_SLAVE_ADDR = 2'd0,
        CFG_FUNC_CODE  = 2'd1,
        CFG_REG_COUNT  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] dev_addr;
        logic [7:0] function_code;
        logic [2:0] reg_num;
    } t_cfg;

    typedef struct packed {
        logic        status;
        logic [15:0] first_register;
        logic [15:0] second_register;
    } t_result;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: sv/mrfc_cfg.sv
// Configuration registers: expected address, function code and register count.
// Depends on mrfc_pkg.
module mrfc_cfg
    import mrfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_wr,
    input  logic [1:0] i_index,
    input  logic [7:0] i_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_addr      <= 8'd1;
            r_cfg.function_code <= 8'd3;
            r_cfg.reg_num       <= 3'd2;
        end else if (i_wr) begin
            case (t_cfg_idx'(i_index))
                CFG_SLAVE_ADDR: r_cfg.dev_addr      <= i_data;
                CFG_FUNC_CODE:  r_cfg.function_code <= i_data;
                CFG_REG_COUNT:  r_cfg.reg_num       <= i_data[2:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/mrfc_track.sv
// Frame state: byte count, running CRC, tail delay line, header check, capture.
// Forms the frame result combinationally from the byte being stepped in.
// Depends on mrfc_pkg.
module mrfc_track
    import mrfc_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    localparam int unsigned CW = $clog2(MAX_FRAME + 1);
    localparam int unsigned EW = (CW > 5) ? CW : 5;

    logic [CW-1:0] r_cnt,   n_cnt;
    logic [15:0]   r_crc,   n_crc;
    logic [7:0]    r_tail0, n_tail0;
    logic [7:0]    r_tail1, n_tail1;
    logic          r_hdr,   n_hdr;
    logic [15:0]   r_cap0,  n_cap0;
    logic [15:0]   r_cap1,  n_cap1;

    logic [EW-1:0] expected;
    logic          ok;

    always_comb begin
        n_cnt   = r_cnt;
        n_crc   = r_crc;
        n_tail0 = r_tail0;
        n_tail1 = r_tail1;
        n_hdr   = r_hdr;
        n_cap0  = r_cap0;
        n_cap1  = r_cap1;
        if (r_cnt < CW'(MAX_FRAME)) begin
            if (r_cnt >= CW'(POS_COUNT)) begin
                n_crc = crc_byte(r_crc, r_tail0);
            end
            n_tail0 = r_tail1;
            n_tail1 = i_byte;
            if (r_cnt == CW'(POS_ADDR) && i_byte != i_cfg.dev_addr) begin
                n_hdr = 1'b0;
            end
            if (r_cnt == CW'(POS_FUNC) && i_byte != i_cfg.function_code) begin
                n_hdr = 1'b0;
            end
            if (r_cnt == CW'(POS_COUNT) && i_byte != {4'd0, i_cfg.reg_num, 1'b0}) begin
                n_hdr = 1'b0;
            end
            if (r_cnt == CW'(POS_R0_HI)) n_cap0[15:8] = i_byte;
            if (r_cnt == CW'(POS_R0_LO)) n_cap0[7:0]  = i_byte;
            if (r_cnt == CW'(POS_R1_HI)) n_cap1[15:8] = i_byte;
            if (r_cnt == CW'(POS_R1_LO)) n_cap1[7:0]  = i_byte;
            n_cnt = r_cnt + 1'b1;
        end

        expected = EW'(LEN_BASE) + EW'({i_cfg.reg_num, 1'b0});
        ok = (EW'(n_cnt) == expected) && n_hdr && ({n_tail1, n_tail0} == n_crc);

        o_result.status          = !ok;
        o_result.first_register  = (ok && i_cfg.reg_num >= 3'd1) ? n_cap0 : 16'd0;
        o_result.second_register = (ok && i_cfg.reg_num >= 3'd2) ? n_cap1 : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_cnt   <= '0;
            r_crc   <= CRC_INIT;
            r_tail0 <= 8'd0;
            r_tail1 <= 8'd0;
            r_hdr   <= 1'b1;
            r_cap0  <= 16'd0;
            r_cap1  <= 16'd0;
        end else if (i_step) begin
            r_cnt   <= n_cnt;
            r_crc   <= n_crc;
            r_tail0 <= n_tail0;
            r_tail1 <= n_tail1;
            r_hdr   <= n_hdr;
            r_cap0  <= n_cap0;
            r_cap1  <= n_cap1;
        end
    end

endmodule

FILE: sv/modbus_response_frame_checker_unit.sv
// Modbus RTU read-holding-registers response checker, top level.
// The result is registered: the last byte passes the input register, then the result register.
// Throughput: one byte per cycle; a last byte holds in the input register only while
// the result register is full and stalled.
// Reset (synchronous, active low) restores the register defaults and clears the frame.
// Depends on mrfc_pkg, mrfc_cfg and mrfc_track.
module modbus_response_frame_checker_unit
    import mrfc_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_status,
    output logic [15:0] o_first_register,
    output logic [15:0] o_second_register
);

    t_cfg    cfg;
    t_result result;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    logic       r_out_valid;
    t_result    r_out;

    logic out_free;
    logic step;

    assign o_cfg_ready = 1'b1;

    mrfc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && (!r_in_end || out_free);
    assign o_in_stall = r_in_valid && !step;

    mrfc_track #(
        .MAX_FRAME (MAX_FRAME)
    ) u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_last   (r_in_end),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_rx_byte;
            r_in_end  <= i_frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_end) begin
            r_out <= result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out.status;
    assign o_first_register  = r_out.first_register;
    assign o_second_register = r_out.second_register;

endmodule

FILE: sv/mrfc_checker.sv
// Port-level checks for the response frame checker, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module mrfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_status,
    input logic [15:0] o_first_register,
    input logic [15:0] o_second_register
);

    logic [32:0] out_payload;

    assign out_payload = {o_status, o_first_register, o_second_register};

    `ASSERT_NEXT(a_out_valid_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `ASSERT_NEXT(a_out_data_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(out_payload))
    `ASSERT_SAME(a_err_zero, i_clk, i_rst_n, o_out_valid && o_status, out_payload[31:0] == 32'd0)
    `ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

endmodule

bind modbus_response_frame_checker_unit mrfc_checker u_mrfc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_status          (o_status),
    .o_first_register  (o_first_register),
    .o_second_register (o_second_register)
);
